>>> rtl/hbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker package
// Shared constants, codes, control types and the hex digit decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

   localparam int LEN_BITS_DEF = 32;
   localparam int REG_W        = 32;
   localparam int CSR_IDX_W    = 2;

   localparam logic [REG_W-1:0] MAX_CHUNK_RST = 32'd1048576;
   localparam logic [REG_W-1:0] MAX_BODY_RST  = 32'd1048576;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   // Number of bytes skipped after the data of a chunk.
   localparam int TRAIL_SKIP = 2;

   localparam logic [1:0] MODE_CHUNKED = 2'd0;
   localparam logic [1:0] MODE_LENGTH  = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_BODY_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTENT_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_LIMIT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_LIMIT     = 2'd3;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_EXT     = 3'd1,
      PH_SIZE_CR = 3'd2,
      PH_EXT_CR  = 3'd3,
      PH_DATA    = 3'd4,
      PH_TRAIL   = 3'd5
   } hbd_phase_type;

   typedef enum logic [2:0] {
      ST_RUN  = 3'd0,
      ST_DONE = 3'd1,
      ST_BAD  = 3'd2,
      ST_BIG  = 3'd3,
      ST_NUM  = 3'd4
   } hbd_status_type;

   typedef struct packed {
      hbd_phase_type  phase;
      logic           digit_seen;
      hbd_status_type final_status;
   } hbd_ctl_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hbd_hex_type;

   // Decodes one ASCII hex digit; ok is low for any other byte.
   function automatic hbd_hex_type hex_decode(input logic [7:0] c);
      hbd_hex_type r;
      r.ok     = 1'b1;
      r.nibble = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r.nibble = 4'(c - 8'h30);
      end else if (c inside {[8'h61:8'h66]}) begin
         r.nibble = 4'(c - 8'h57);
      end else if (c inside {[8'h41:8'h46]}) begin
         r.nibble = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> rtl/hbd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker channel interfaces
// Raw body byte channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_body;

   modport source (output valid, output data_byte, output start_of_body, input ready);
   modport sink (input valid, input data_byte, input start_of_body, output ready);
endinterface

interface hbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       body_valid;
   logic [2:0] status;

   modport source (output valid, output body_byte, output body_valid, output status,
                   input ready);
   modport sink (input valid, input body_byte, input body_valid, input status,
                 output ready);
endinterface

>>> rtl/hbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker step logic
// Next parse state and result word for one body byte.
// ----------------------------------------------------------------------------
module hbd_step
   import hbd_pkg::*;
#(
   parameter int LEN_BITS = LEN_BITS_DEF
) (
   input  logic [1:0]          body_mode,
   input  logic [REG_W-1:0]    content_length,
   input  logic [REG_W-1:0]    chunk_limit,
   input  logic [REG_W-1:0]    body_limit,
   input  logic [7:0]          data_byte,
   input  logic                start_of_body,
   input  hbd_ctl_type         ctl_cur,
   input  logic [LEN_BITS-1:0] hex_cur,
   input  logic [LEN_BITS-1:0] left_cur,
   input  logic [LEN_BITS-1:0] total_cur,
   output hbd_ctl_type         ctl_nxt,
   output logic [LEN_BITS-1:0] hex_nxt,
   output logic [LEN_BITS-1:0] left_nxt,
   output logic [LEN_BITS-1:0] total_nxt,
   output logic [7:0]          body_byte,
   output logic                body_valid
);

   localparam int CMP_W = (LEN_BITS > REG_W) ? LEN_BITS : REG_W;

   hbd_ctl_type         ctl_s;
   logic [LEN_BITS-1:0] hex_s;
   logic [LEN_BITS-1:0] left_s;
   logic [LEN_BITS-1:0] total_s;
   logic [LEN_BITS-1:0] left_dec;
   logic [CMP_W-1:0]    hex_x;
   logic [CMP_W-1:0]    total_x;
   logic                line_bad;
   logic                body_full;
   logic                len_full;
   logic                pay;
   hbd_hex_type         dig;

   always_comb begin
      // Start of body clears the parse state before the byte is looked at.
      if (start_of_body) begin
         ctl_s   = '{phase: PH_SIZE, digit_seen: 1'b0, final_status: ST_RUN};
         hex_s   = '0;
         left_s  = '0;
         total_s = '0;
      end else begin
         ctl_s   = ctl_cur;
         hex_s   = hex_cur;
         left_s  = left_cur;
         total_s = total_cur;
      end

      hex_x     = CMP_W'(hex_s);
      total_x   = CMP_W'(total_s);
      left_dec  = left_s - LEN_BITS'(1);
      line_bad  = hex_x > CMP_W'(chunk_limit);
      body_full = (total_x >= CMP_W'(body_limit)) || (&total_s);
      len_full  = (total_x >= CMP_W'(content_length)) || (&total_s);
      dig       = hex_decode(data_byte);

      ctl_nxt   = ctl_s;
      hex_nxt   = hex_s;
      left_nxt  = left_s;
      total_nxt = total_s;
      pay       = 1'b0;

      if (ctl_s.final_status == ST_RUN) begin
         if (body_mode == MODE_CHUNKED) begin
            case (ctl_s.phase)
               PH_EXT: begin
                  if (data_byte == CHAR_CR) ctl_nxt.phase = PH_EXT_CR;
               end
               PH_SIZE_CR, PH_EXT_CR: begin
                  if (data_byte == CHAR_LF) begin
                     // End of the size line.
                     if (!ctl_s.digit_seen) begin
                        ctl_nxt.final_status = ST_NUM;
                     end else if (line_bad) begin
                        ctl_nxt.final_status = ST_BAD;
                     end else if (hex_s == '0) begin
                        ctl_nxt.final_status = ST_DONE;
                     end else begin
                        left_nxt      = hex_s;
                        ctl_nxt.phase = PH_DATA;
                     end
                  end else if (ctl_s.phase == PH_SIZE_CR) begin
                     ctl_nxt.final_status = ST_NUM;
                  end else if (data_byte != CHAR_CR) begin
                     ctl_nxt.phase = PH_EXT;
                  end
               end
               PH_DATA: begin
                  if (body_full) begin
                     ctl_nxt.final_status = ST_BIG;
                  end else begin
                     pay       = 1'b1;
                     total_nxt = total_s + LEN_BITS'(1);
                     left_nxt  = left_dec;
                     if (left_dec == '0) begin
                        left_nxt      = LEN_BITS'(TRAIL_SKIP);
                        ctl_nxt.phase = PH_TRAIL;
                     end
                  end
               end
               PH_TRAIL: begin
                  left_nxt = left_dec;
                  if (left_dec == '0) begin
                     ctl_nxt.phase      = PH_SIZE;
                     ctl_nxt.digit_seen = 1'b0;
                     hex_nxt            = '0;
                  end
               end
               default: begin
                  ctl_nxt.phase = PH_SIZE;
                  if (data_byte == CHAR_SEMI) begin
                     ctl_nxt.phase = PH_EXT;
                  end else if (data_byte == CHAR_CR) begin
                     ctl_nxt.phase = PH_SIZE_CR;
                  end else if (!dig.ok) begin
                     ctl_nxt.final_status = ST_NUM;
                  end else if (hex_s[LEN_BITS-1 -: 4] != 4'd0) begin
                     ctl_nxt.final_status = ST_BAD;
                  end else begin
                     hex_nxt            = {hex_s[LEN_BITS-5:0], dig.nibble};
                     ctl_nxt.digit_seen = 1'b1;
                  end
               end
            endcase
         end else if (body_mode == MODE_LENGTH) begin
            if (content_length > body_limit) begin
               ctl_nxt.final_status = ST_BIG;
            end else if (len_full) begin
               ctl_nxt.final_status = ST_BAD;
            end else begin
               pay       = 1'b1;
               total_nxt = total_s + LEN_BITS'(1);
               if (CMP_W'(total_nxt) == CMP_W'(content_length)) begin
                  ctl_nxt.final_status = ST_DONE;
               end
            end
         end else begin
            ctl_nxt.final_status = ST_BAD;
         end
      end

      body_valid = pay;
      body_byte  = pay ? data_byte : 8'd0;
   end

endmodule

>>> rtl/http_body_dechunker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker unit
// Decodes a chunked or length-delimited HTTP body, one raw byte per word.
// ----------------------------------------------------------------------------
//   port        dir   handshake     payload
//   req_chan    in    valid/ready   data_byte[7:0], start_of_body
//   rsp_chan    out   valid/ready   body_byte[7:0], body_valid, status[2:0]
//   csr_*       in    wr_en only    csr_index[1:0], csr_wr_data[31:0]
//
// The unit takes one word per cycle while the result register is not stalled
// and returns exactly one result word for each. A word is held in the input
// register, then the combinational step logic updates the parse state and
// loads the result register, so each result passes through the input and
// result registers. The combinational parse state update is what sets the
// rate of one word per cycle.
// Reset is synchronous and active high; it clears the pipeline, parse state
// and configuration registers to their reset values.
// A stalled result register holds its word; the input register keeps filling
// while the result register is free or being drained, so both sides stall
// independently with no lost cycle.
// ----------------------------------------------------------------------------
module http_body_dechunker_unit
   import hbd_pkg::*;
#(
   parameter int LEN_BITS = LEN_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   hbd_req_if.sink              req_chan,
   hbd_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wr_data
);

   // Configuration registers.
   logic [1:0]       body_mode_ff;
   logic [REG_W-1:0] content_length_ff;
   logic [REG_W-1:0] chunk_limit_ff;
   logic [REG_W-1:0] body_limit_ff;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // Parse state and its next value from the step logic.
   hbd_ctl_type         ctl_ff;
   hbd_ctl_type         ctl_in;
   logic [LEN_BITS-1:0] hex_ff;
   logic [LEN_BITS-1:0] hex_in;
   logic [LEN_BITS-1:0] left_ff;
   logic [LEN_BITS-1:0] left_in;
   logic [LEN_BITS-1:0] total_ff;
   logic [LEN_BITS-1:0] total_in;

   // Result register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_body_valid_ff;
   logic [2:0] rsp_status_ff;
   logic [7:0] rsp_byte_in;
   logic       rsp_body_valid_in;

   logic advance;
   logic in_ready;

   // The word in the input register moves on whenever the result register is
   // empty or is being drained in this cycle.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign in_ready = !in_valid_ff || advance;

   assign req_chan.ready      = in_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.body_byte  = rsp_byte_ff;
   assign rsp_chan.body_valid = rsp_body_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_mode_ff      <= MODE_CHUNKED;
         content_length_ff <= '0;
         chunk_limit_ff    <= MAX_CHUNK_RST;
         body_limit_ff     <= MAX_BODY_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BODY_MODE:      body_mode_ff      <= csr_wr_data[1:0];
            CSR_CONTENT_LENGTH: content_length_ff <= csr_wr_data;
            CSR_CHUNK_LIMIT:    chunk_limit_ff    <= csr_wr_data;
            CSR_BODY_LIMIT:     body_limit_ff     <= csr_wr_data;
            default:            ;
         endcase
      end
   end

   hbd_step #(
      .LEN_BITS (LEN_BITS)
   ) u_step (
      .body_mode      (body_mode_ff),
      .content_length (content_length_ff),
      .chunk_limit    (chunk_limit_ff),
      .body_limit     (body_limit_ff),
      .data_byte      (in_byte_ff),
      .start_of_body  (in_start_ff),
      .ctl_cur        (ctl_ff),
      .hex_cur        (hex_ff),
      .left_cur       (left_ff),
      .total_cur      (total_ff),
      .ctl_nxt        (ctl_in),
      .hex_nxt        (hex_in),
      .left_nxt       (left_in),
      .total_nxt      (total_in),
      .body_byte      (rsp_byte_in),
      .body_valid     (rsp_body_valid_in)
   );

   // Input register: payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (in_ready && req_chan.valid) begin
         in_byte_ff  <= req_chan.data_byte;
         in_start_ff <= req_chan.start_of_body;
      end
   end

   // Parse state advances together with the word it has just consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '{phase: PH_SIZE, digit_seen: 1'b0, final_status: ST_RUN};
         hex_ff   <= '0;
         left_ff  <= '0;
         total_ff <= '0;
      end else if (advance) begin
         ctl_ff   <= ctl_in;
         hex_ff   <= hex_in;
         left_ff  <= left_in;
         total_ff <= total_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_byte_ff       <= rsp_byte_in;
         rsp_body_valid_ff <= rsp_body_valid_in;
         rsp_status_ff     <= 3'(ctl_in.final_status);
      end
   end

   // A payload byte is only ever reported while the body is running or on
   // the byte that completes it.
   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_body_valid_ff |->
         (rsp_status_ff == 3'(ST_RUN)) || (rsp_status_ff == 3'(ST_DONE)))
      else $error("payload byte reported with an error status");

   a_nonpayload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_body_valid_ff |-> rsp_byte_ff == 8'd0)
      else $error("non-payload result carries a nonzero byte");

   // Completion and errors hold until the next start of body.
   a_sticky_status: assert property (@(posedge clock) disable iff (reset)
      advance && !in_start_ff && (ctl_ff.final_status != ST_RUN) |=>
         ctl_ff.final_status == $past(ctl_ff.final_status))
      else $error("final status changed without a start of body");

   a_data_left: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.phase == PH_DATA |-> left_ff != '0)
      else $error("data phase with no bytes left in the chunk");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input word dropped while the result register was stalled");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP body dechunker testbench
// Streams chunked, length-delimited and headerless bodies with random content,
// random sender bursts and receiver stalls into the unit. A behavioral decoder
// predicts every result word, and the scoreboard checks the words in order.
// ----------------------------------------------------------------------------
module tb_top;
   import hbd_pkg::*;

   // The package names only the two usable modes; both other codes mean that
   // no body header was present.
   localparam logic [1:0] MODE_NO_HEADER  = 2'd2;
   localparam logic [1:0] MODE_NO_HEADER3 = 2'd3;

   // Far above the slowest correct run: about 1600 words at worst 0.3 words
   // per cycle, the long receiver hold-off and the idle pauses between phases.
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_body;
   } raw_word_type;

   typedef struct packed {
      logic [7:0]     body_byte;
      logic           body_valid;
      hbd_status_type status;
   } decoded_word_type;

   logic clock;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wr_data;

   hbd_req_if req_bus ();
   hbd_rsp_if rsp_bus ();

   http_body_dechunker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Raw body words waiting to be sent, and decoded words still owed by the unit.
   raw_word_type     raw_backlog[$];
   decoded_word_type decoded_due[$];
   logic             next_sob = 1'b0;

   // Configuration as the unit holds it; the initializers are its reset values.
   logic [1:0]  cfg_mode        = MODE_CHUNKED;
   logic [31:0] cfg_content_len = 32'd0;
   logic [31:0] cfg_chunk_max   = MAX_CHUNK_RST;
   logic [31:0] cfg_body_max    = MAX_BODY_RST;

   // Parse state of the behavioral decoder.
   hbd_phase_type  dk_phase  = PH_SIZE;
   logic [31:0]    dk_accum  = '0;
   logic           dk_digit  = 1'b0;
   logic [31:0]    dk_left   = '0;
   logic [31:0]    dk_total  = '0;
   hbd_status_type dk_status = ST_RUN;

   // Bookkeeping.
   int live_words   = 0;   // words that reached the parser (not ignored)
   int raw_queued   = 0;
   int raw_sent     = 0;
   int results_seen = 0;
   int payload_seen = 0;
   int mismatches   = 0;
   int cycle_count  = 0;
   int status_hits[8];
   bit steady       = 1'b0;   // no sender gaps and no receiver stalls
   bit hold_done    = 1'b0;

   // Sender and receiver pacing.
   int          send_burst = 0;
   int          send_gap   = 0;
   int          hold_left  = 0;
   int          stall_age  = 0;
   logic [31:0] stall_mask = '0;
   raw_word_type     next_raw;
   decoded_word_type want;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Behavioral decoder
   // -------------------------------------------------------------------------

   // End of a size line: no digit is malformed, a size above the limit is a bad
   // request, a zero size completes the body, anything else opens the data.
   function automatic hbd_status_type close_size_line();
      if (!dk_digit) return ST_NUM;
      if (dk_accum > cfg_chunk_max) return ST_BAD;
      if (dk_accum == 0) return ST_DONE;
      dk_left  = dk_accum;
      dk_phase = PH_DATA;
      return ST_RUN;
   endfunction

   // Advances the parse state by one raw byte and returns the word the unit
   // must produce for it.
   function automatic decoded_word_type decode_byte(input logic [7:0] c, input logic sob);
      decoded_word_type w;
      logic             pass;
      logic             nib_ok;
      logic [3:0]       nib;
      pass = 1'b0;
      if (sob) begin
         dk_phase  = PH_SIZE;
         dk_accum  = '0;
         dk_digit  = 1'b0;
         dk_left   = '0;
         dk_total  = '0;
         dk_status = ST_RUN;
      end
      // Once a body has ended or failed, every byte is ignored until the
      // next start of body, and the final status is repeated.
      if (dk_status == ST_RUN) begin
         live_words++;
         if (cfg_mode == MODE_CHUNKED) begin
            case (dk_phase)
               PH_EXT: begin
                  if (c == CHAR_CR) dk_phase = PH_EXT_CR;
               end
               PH_SIZE_CR: begin
                  dk_status = (c == CHAR_LF) ? close_size_line() : ST_NUM;
               end
               PH_EXT_CR: begin
                  if (c == CHAR_LF) dk_status = close_size_line();
                  else if (c != CHAR_CR) dk_phase = PH_EXT;
               end
               PH_DATA: begin
                  if (dk_total >= cfg_body_max || dk_total == '1) begin
                     dk_status = ST_BIG;
                  end else begin
                     dk_total++;
                     dk_left--;
                     if (dk_left == 0) begin
                        dk_left  = 32'(TRAIL_SKIP);
                        dk_phase = PH_TRAIL;
                     end
                     pass = 1'b1;
                  end
               end
               PH_TRAIL: begin
                  // The two bytes after the data are dropped without a look.
                  dk_left--;
                  if (dk_left == 0) begin
                     dk_phase = PH_SIZE;
                     dk_accum = '0;
                     dk_digit = 1'b0;
                  end
               end
               default: begin
                  dk_phase = PH_SIZE;
                  nib_ok = 1'b1;
                  nib    = c[3:0];
                  if (c >= 8'h30 && c <= 8'h39) nib = c[3:0];
                  else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
                     nib = c[3:0] + 4'd9;
                  else nib_ok = 1'b0;
                  if (c == CHAR_SEMI) dk_phase = PH_EXT;
                  else if (c == CHAR_CR) dk_phase = PH_SIZE_CR;
                  else if (!nib_ok) dk_status = ST_NUM;
                  else if (dk_accum > 32'h0FFF_FFFF) dk_status = ST_BAD;
                  else begin
                     dk_accum = {dk_accum[27:0], nib};
                     dk_digit = 1'b1;
                  end
               end
            endcase
         end else if (cfg_mode == MODE_LENGTH) begin
            if (cfg_content_len > cfg_body_max) begin
               dk_status = ST_BIG;
            end else if (dk_total >= cfg_content_len || dk_total == '1) begin
               dk_status = ST_BAD;
            end else begin
               dk_total++;
               pass = 1'b1;
               if (dk_total == cfg_content_len) dk_status = ST_DONE;
            end
         end else begin
            dk_status = ST_BAD;
         end
      end
      w.body_byte  = pass ? c : 8'd0;
      w.body_valid = pass;
      w.status     = dk_status;
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Sender: bursts of random length with random gaps in between. The word
   // accepted at this edge is handed to the decoder before the next is loaded.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.data_byte     <= 8'd0;
         req_bus.start_of_body <= 1'b0;
         send_burst = 0;
         send_gap   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decoded_due.push_back(decode_byte(req_bus.data_byte, req_bus.start_of_body));
            raw_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0 && !steady) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (raw_backlog.size() != 0) begin
               next_raw = raw_backlog.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.data_byte     <= next_raw.data_byte;
               req_bus.start_of_body <= next_raw.start_of_body;
               if (send_burst > 0) begin
                  send_burst--;
               end else begin
                  send_burst = $urandom_range(1, 40);
                  send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stalls on a rotating random pattern that is redrawn whenever its
   // random age runs out, sometimes all clear. Once, while plenty of words are still
   // queued, it holds off for the LONG_HOLD stretch so that the unit fills up and
   // stalls its input.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left  = 0;
         stall_age  = 0;
         stall_mask = '0;
      end else begin
         if (!hold_done && raw_sent > 400 && raw_backlog.size() > 40) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            if (stall_age == 0) begin
               stall_age  = $urandom_range(16, 96);
               stall_mask = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
            end
            stall_age--;
            rsp_bus.ready <= !stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[31:1]};
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: each result word is checked against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         status_hits[rsp_bus.status]++;
         if (rsp_bus.body_valid === 1'b1) payload_seen++;
         if (decoded_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: byte %02h valid %0b status %0d",
                        rsp_bus.body_byte, rsp_bus.body_valid, rsp_bus.status);
         end else begin
            want = decoded_due.pop_front();
            if (rsp_bus.body_byte !== want.body_byte || rsp_bus.body_valid !== want.body_valid
                || rsp_bus.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected byte %02h valid %0b status %0d, got %02h %0b %0d",
                           results_seen, want.body_byte, want.body_valid, want.status,
                           rsp_bus.body_byte, rsp_bus.body_valid, rsp_bus.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, decoded_due.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus building blocks
   // -------------------------------------------------------------------------

   // Queues one raw byte; only the first byte after next_sob is set starts a body.
   task automatic add_byte(input logic [7:0] b);
      raw_word_type w;
      w.data_byte     = b;
      w.start_of_body = next_sob;
      raw_backlog.push_back(w);
      raw_queued++;
      next_sob = 1'b0;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_crlf();
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endtask

   // A chunked body: mostly well-formed chunks with random sizes, case, leading
   // zeros, extensions and data, now and then broken in one of the ways the
   // decoder must catch, after which the rest of the body is abandoned.
   task automatic add_chunked_body();
      int    chunks;
      int    size;
      int    pick;
      string digits;
      next_sob = 1'b1;
      chunks   = $urandom_range(1, 4);
      for (int i = 0; i < chunks; i++) begin
         pick = $urandom_range(0, 39);
         if (pick == 0) begin
            // Some arbitrary byte where a size digit belongs.
            add_byte(8'($urandom()));
            add_crlf();
            return;
         end else if (pick == 1) begin
            // Size line with no digits at all.
            add_crlf();
            return;
         end else if (pick == 2) begin
            // Nine digits with a nonzero lead cannot fit in 32 bits.
            add_text($sformatf("%0h%08h", $urandom_range(1, 15), $urandom()));
            add_crlf();
            return;
         end else if (pick == 3) begin
            // Large declared size; only a few of its bytes follow.
            add_text($sformatf("%0h", ($urandom_range(0, 1) == 1) ? $urandom()
                                                                 : $urandom_range(13, 1000)));
            add_crlf();
            repeat ($urandom_range(3, 20)) add_byte(8'($urandom()));
            return;
         end else if (pick == 4) begin
            // Carriage return inside the size that is not followed by LF.
            add_text("5");
            add_byte(CHAR_CR);
            add_byte(($urandom_range(0, 1) == 1) ? CHAR_CR : 8'($urandom()));
            return;
         end
         size   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         digits = $sformatf("%0h", size);
         if ($urandom_range(0, 1) == 1) digits = digits.toupper();
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) add_text("0");
         add_text(digits);
         if ($urandom_range(0, 3) == 0) begin
            add_byte(CHAR_SEMI);
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 4) == 0) begin
               // A CR inside the extension that does not end the line.
               add_byte(CHAR_CR);
               add_byte(($urandom_range(0, 1) == 1) ? CHAR_CR : 8'h78);
            end
         end
         add_crlf();
         repeat (size) add_byte(8'($urandom()));
         if ($urandom_range(0, 7) == 0) begin
            add_byte(8'($urandom()));
            add_byte(8'($urandom()));
         end else begin
            add_crlf();
         end
      end
      // Usually the zero-size terminator and a short trailer, which is ignored.
      if ($urandom_range(0, 5) != 0) begin
         add_text("0");
         add_crlf();
         repeat ($urandom_range(0, 3)) add_byte(8'($urandom()));
      end
   endtask

   // One body shaped for the current mode, sometimes preceded by noise words
   // that may raise start of body in odd places.
   task automatic add_body();
      int n;
      if ($urandom_range(0, 15) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            next_sob = 1'($urandom_range(0, 1));
            add_byte(8'($urandom()));
         end
      end
      if (cfg_mode == MODE_CHUNKED) begin
         add_chunked_body();
      end else begin
         n = $urandom_range(1, 3);
         if (cfg_mode == MODE_LENGTH && cfg_content_len != 0
             && cfg_content_len <= cfg_body_max) begin
            if (cfg_content_len <= 64) begin
               n = int'(cfg_content_len);
               if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
               else if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
            end else begin
               n = $urandom_range(3, 40);
            end
         end
         next_sob = 1'b1;
         repeat (n) add_byte(8'($urandom()));
      end
   endtask

   // Lets the sender drain and waits until every result is in, plus the
   // pipeline depth, so that the unit is idle.
   task automatic wait_idle();
      while (raw_backlog.size() != 0 || decoded_due.size() != 0 || req_bus.valid
             || rsp_bus.valid) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Writes all four registers, one per cycle, while the unit is idle.
   task automatic configure(input logic [1:0] mode, input logic [31:0] clen,
                            input logic [31:0] chunk_max, input logic [31:0] body_max);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_BODY_MODE;
      csr_wr_data <= {30'd0, mode};
      @(posedge clock);
      csr_index   <= CSR_CONTENT_LENGTH;
      csr_wr_data <= clen;
      @(posedge clock);
      csr_index   <= CSR_CHUNK_LIMIT;
      csr_wr_data <= chunk_max;
      @(posedge clock);
      csr_index   <= CSR_BODY_LIMIT;
      csr_wr_data <= body_max;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_mode        = mode;
      cfg_content_len = clen;
      cfg_chunk_max   = chunk_max;
      cfg_body_max    = body_max;
      @(posedge clock);
   endtask

   // Keeps the backlog topped up with bodies until the given number of raw
   // words has been queued, then lets everything drain.
   task automatic run_phase(input int target);
      int goal;
      goal = raw_queued + target;
      while (raw_queued < goal) begin
         if (raw_backlog.size() < 96) add_body();
         else @(posedge clock);
      end
      wait_idle();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_BODY_MODE;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // Directed bodies under the reset configuration: a complete chunked body
      // with an extension, extreme data values and an ignored trailer; an empty
      // size line; a stray letter in the size; a lone CR; a size that overflows.
      next_sob = 1'b1;
      add_text("2;z");
      add_crlf();
      add_byte(8'h00);
      add_byte(8'hFF);
      add_crlf();
      add_text("0");
      add_crlf();
      add_text("x");
      next_sob = 1'b1;
      add_crlf();
      next_sob = 1'b1;
      add_text("1G");
      next_sob = 1'b1;
      add_byte(CHAR_CR);
      add_text("a");
      next_sob = 1'b1;
      add_text("123456789");
      wait_idle();

      // Chunked at the reset limits.
      configure(MODE_CHUNKED, 32'd0, MAX_CHUNK_RST, MAX_BODY_RST);
      run_phase(300);
      // Tight limits: oversized chunks and bodies that grow too long.
      configure(MODE_CHUNKED, 32'd7, 32'd8, 32'd20);
      run_phase(250);
      // Length mode with a short declared length.
      configure(MODE_LENGTH, 32'd16, MAX_CHUNK_RST, MAX_BODY_RST);
      run_phase(250);
      // Largest length and limits: bytes pass and the body never completes.
      configure(MODE_LENGTH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_phase(150);
      // Declared length above the body limit.
      configure(MODE_LENGTH, 32'd40, 32'd0, 32'd30);
      run_phase(30);
      // Zero length: the first byte is already one too many.
      configure(MODE_LENGTH, 32'd0, MAX_CHUNK_RST, MAX_BODY_RST);
      run_phase(30);
      // No usable header in either encoding.
      configure(MODE_NO_HEADER, 32'd5, MAX_CHUNK_RST, MAX_BODY_RST);
      run_phase(20);
      configure(MODE_NO_HEADER3, 32'd5, MAX_CHUNK_RST, MAX_BODY_RST);
      run_phase(20);
      // Zero limits: only an empty body can complete.
      configure(MODE_CHUNKED, 32'd0, 32'd0, 32'd0);
      run_phase(60);
      // Widest limits with both sides running flat out.
      configure(MODE_CHUNKED, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      steady = 1'b1;
      run_phase(300);
      steady = 1'b0;

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Covered %0d raw words (%0d parsed, the rest ignored) in %0d cycles.",
               raw_sent, live_words, cycle_count);
      $display("Checked %0d results: %0d payload, status run/done/bad/big/num %0d/%0d/%0d/%0d/%0d.",
               results_seen, payload_seen, status_hits[ST_RUN], status_hits[ST_DONE],
               status_hits[ST_BAD], status_hits[ST_BIG], status_hits[ST_NUM]);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("%0d result words were wrong or unexpected", mismatches);
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/hbd_pkg.sv
rtl/hbd_if.sv
rtl/hbd_step.sv
rtl/http_body_dechunker_unit.sv
tb/sv/tb_top.sv
